// ----- rtl/core/lnrr_pkg.sv -----
// Package for the luminance nearest ramp remap block.
// Holds the opcode and payload types and the fixed arithmetic constants.
// No dependencies; lnrr_luma and the top level import it.
package lnrr_pkg;

   // Field widths of the items.
   localparam int COLOR_W  = 8;
   localparam int BRIGHT_W = 7;

   // Item operations.
   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_MAP  = 1'b1
   } lnrr_op_type;

   // Brightness weights, each applied before its own division by 5000.
   localparam logic [10:0] COEF_R = 11'd1063;
   localparam logic [11:0] COEF_G = 12'd3576;
   localparam logic [8:0]  COEF_B = 9'd361;

   // Division by 5000 as a multiply by ceil(2^32 / 5000) and a shift.
   // The rounding error keeps the quotient exact for dividends below 2^20.
   localparam logic [19:0] RECIP_5000 = 20'd858994;
   localparam int          RECIP_SHIFT = 32;

   // Division by 3 of an 8-bit sum: multiply by 171 and shift by 9.
   localparam logic [7:0] DIV3_MUL   = 8'd171;
   localparam int         DIV3_SHIFT = 9;

   // Palette indices that always map to themselves.
   localparam logic [COLOR_W-1:0] FIXED_INDEX_LO = 8'd0;
   localparam logic [COLOR_W-1:0] FIXED_INDEX_HI = 8'd31;

   // Colour carried by an item.
   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } lnrr_rgb_type;

   // Request and answer of the brightness unit.
   typedef struct packed {
      logic         valid;
      lnrr_rgb_type rgb;
   } lnrr_luma_req_type;

   typedef struct packed {
      logic                valid;
      logic [BRIGHT_W-1:0] bright;
   } lnrr_luma_rsp_type;

   // One ramp slot as held in the memory.
   typedef struct packed {
      logic [BRIGHT_W-1:0] bright;
      logic [COLOR_W-1:0]  color;
   } lnrr_slot_type;

endpackage

// ----- rtl/core/lnrr_if.sv -----
// Handshake channels of the luminance nearest ramp remap block.
// lnrr_req_if carries input items, lnrr_rsp_if carries result items.
// No dependencies.
interface lnrr_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [3:0] slot;
   logic [7:0] ramp_color;
   logic [7:0] color_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (
      output valid, opcode, slot, ramp_color, color_index, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, opcode, slot, ramp_color, color_index, red, green, blue,
      output ready
   );
endinterface

interface lnrr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] mapped_index;

   modport source (
      output valid, mapped_index,
      input  ready
   );
   modport sink (
      input  valid, mapped_index,
      output ready
   );
endinterface

// ----- rtl/core/lnrr_luma.sv -----
// Three-stage pipelined brightness unit of the ramp remap block.
// Computes (1063*r/5000 + 3576*g/5000 + 361*b/5000)/3 with truncating divisions.
// Depends on lnrr_pkg.
module lnrr_luma
   import lnrr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lnrr_luma_req_type luma_req,
   output lnrr_luma_rsp_type luma_rsp
);

   logic [2:0]          vld_ff;
   logic [18:0]         pr_ff;
   logic [19:0]         pg_ff;
   logic [16:0]         pb_ff;
   logic [39:0]         prod_r;
   logic [39:0]         prod_g;
   logic [39:0]         prod_b;
   logic [5:0]          qr_ff;
   logic [7:0]          qg_ff;
   logic [4:0]          qb_ff;
   logic [7:0]          sum;
   logic [15:0]         prod_3;
   logic [BRIGHT_W-1:0] bright_ff;

   // Valid bits travel alongside the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 3'b000;
      end else begin
         vld_ff <= {vld_ff[1:0], luma_req.valid};
      end
   end

   // Stage one weights each component.
   always_ff @(posedge clock) begin
      pr_ff <= {8'd0, COEF_R} * {11'd0, luma_req.rgb.red};
      pg_ff <= {8'd0, COEF_G} * {12'd0, luma_req.rgb.green};
      pb_ff <= {8'd0, COEF_B} * {9'd0, luma_req.rgb.blue};
   end

   // Stage two divides each weighted component by 5000 through the reciprocal.
   assign prod_r = {21'd0, pr_ff} * {20'd0, RECIP_5000};
   assign prod_g = {20'd0, pg_ff} * {20'd0, RECIP_5000};
   assign prod_b = {23'd0, pb_ff} * {20'd0, RECIP_5000};

   always_ff @(posedge clock) begin
      qr_ff <= prod_r[RECIP_SHIFT +: 6];
      qg_ff <= prod_g[RECIP_SHIFT +: 8];
      qb_ff <= prod_b[RECIP_SHIFT +: 5];
   end

   // Stage three adds the quotients and divides the sum by three.
   assign sum    = {2'd0, qr_ff} + qg_ff + {3'd0, qb_ff};
   assign prod_3 = {8'd0, sum} * {8'd0, DIV3_MUL};

   always_ff @(posedge clock) begin
      bright_ff <= prod_3[DIV3_SHIFT +: BRIGHT_W];
   end

   assign luma_rsp.valid  = vld_ff[2];
   assign luma_rsp.bright = bright_ff;

endmodule

// ----- rtl/core/luminance_nearest_ramp_remap.sv -----
// Top level of the luminance nearest ramp remap block.
// Depends on lnrr_pkg, the channel interfaces in lnrr_if and lnrr_luma.
//
// Usage. Items arrive on req_ch. A load item (opcode 0) stores the palette
// index ramp_color and the brightness of its colour in ramp slot "slot"; a
// slot at or beyond RAMP_SIZE is ignored and no result is returned. A map
// item (opcode 1) returns one result on rsp_ch: the palette index held by the
// slot whose brightness lies closest to that of the item's colour, the lowest
// slot winning a tie. Indices 0 and 31 are returned unchanged. Every slot must
// be loaded before the first map item.
// Timing. The block works on one item at a time. A load item is written when
// the brightness unit returns its brightness, and the block is then ready
// again. A map item of index 0 or 31 goes to the output register once its
// brightness has come back. Any other map item reads the ramp memory one slot a
// cycle; once the last slot is compared, its result enters the output register
// when that register is free, and the block then takes the next item.
// Reset clears the control state; the ramp memory keeps its contents. The
// output register holds a result while the receiver stalls, and the block
// accepts the next item meanwhile; a further result waits until it is taken.
module luminance_nearest_ramp_remap
   import lnrr_pkg::*;
#(
   parameter int RAMP_SIZE = 16
) (
   input  logic              clock,
   input  logic              reset,
   lnrr_req_if.sink          req_ch,
   lnrr_rsp_if.source        rsp_ch
);

   localparam int AW = (RAMP_SIZE > 1) ? $clog2(RAMP_SIZE) : 1;
   localparam int CW = $clog2(RAMP_SIZE + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LUMA = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } lnrr_state_type;

   lnrr_state_type      state_ff;
   lnrr_state_type      state_in;
   lnrr_op_type         opcode_ff;
   logic [3:0]          slot_ff;
   logic [COLOR_W-1:0]  ramp_color_ff;
   logic [COLOR_W-1:0]  color_index_ff;
   logic [BRIGHT_W-1:0] bright_ff;
   logic [CW-1:0]       cnt_ff;
   logic [CW-1:0]       cnt_in;
   logic                rd_vld_ff;
   logic                rd_first_ff;
   logic                rd_last_ff;
   lnrr_slot_type       rd_data_ff;
   logic [BRIGHT_W-1:0] best_dif_ff;
   logic [COLOR_W-1:0]  best_color_ff;
   logic                rsp_valid_ff;
   logic [COLOR_W-1:0]  rsp_index_ff;

   lnrr_slot_type       ramp_mem [RAMP_SIZE];

   logic                accept;
   lnrr_luma_req_type   luma_req;
   lnrr_luma_rsp_type   luma_rsp;
   logic [6:0]          slot_ext;
   logic                slot_in_range;
   logic                fixed_index;
   logic                mem_we;
   lnrr_slot_type       wr_data;
   logic                issue;
   logic [BRIGHT_W-1:0] diff;
   logic                take;
   logic                emit_fire;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Brightness of the accepted item's colour.
   assign luma_req.valid     = accept;
   assign luma_req.rgb.red   = req_ch.red;
   assign luma_req.rgb.green = req_ch.green;
   assign luma_req.rgb.blue  = req_ch.blue;

   lnrr_luma u_luma (
      .clock    (clock),
      .reset    (reset),
      .luma_req (luma_req),
      .luma_rsp (luma_rsp)
   );

   // Item fields are held while the item is at work.
   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff      <= lnrr_op_type'(req_ch.opcode);
         slot_ff        <= req_ch.slot;
         ramp_color_ff  <= req_ch.ramp_color;
         color_index_ff <= req_ch.color_index;
      end
      if (state_ff == ST_LUMA && luma_rsp.valid) begin
         bright_ff <= luma_rsp.bright;
      end
   end

   assign slot_ext      = {3'd0, slot_ff};
   assign slot_in_range = (slot_ext < 7'(RAMP_SIZE));
   assign fixed_index   = (color_index_ff == FIXED_INDEX_LO) ||
                          (color_index_ff == FIXED_INDEX_HI);

   // Ramp memory: written by load items, read one slot a cycle during a search.
   assign mem_we         = (state_ff == ST_LUMA) && luma_rsp.valid &&
                           (opcode_ff == OP_LOAD) && slot_in_range;
   assign wr_data.bright = luma_rsp.bright;
   assign wr_data.color  = ramp_color_ff;
   assign issue          = (state_ff == ST_SCAN) && (cnt_ff != CW'(RAMP_SIZE));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ramp_mem[slot_ext[AW-1:0]] <= wr_data;
      end
      rd_data_ff <= ramp_mem[cnt_ff[AW-1:0]];
   end

   // Flags that follow each read to the compare stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= issue;
      end
      rd_first_ff <= (cnt_ff == '0);
      rd_last_ff  <= (cnt_ff == CW'(RAMP_SIZE - 1));
   end

   // Compare stage keeps the slot of smallest brightness difference.
   assign diff = (bright_ff >= rd_data_ff.bright) ? (bright_ff - rd_data_ff.bright)
                                                  : (rd_data_ff.bright - bright_ff);
   assign take = rd_vld_ff && (rd_first_ff || (diff < best_dif_ff));

   always_ff @(posedge clock) begin
      if (state_ff == ST_LUMA) begin
         best_color_ff <= color_index_ff;
      end else if (take) begin
         best_color_ff <= rd_data_ff.color;
         best_dif_ff   <= diff;
      end
   end

   // Sequencer over the stages of one item.
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LUMA;
            end
         end
         ST_LUMA: begin
            cnt_in = '0;
            if (luma_rsp.valid) begin
               if (opcode_ff == OP_LOAD) begin
                  state_in = ST_IDLE;
               end else if (fixed_index) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (rd_vld_ff && rd_last_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Output register holds a result until the receiver takes the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit_fire) begin
         rsp_index_ff <= best_color_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mapped_index = rsp_index_ff;

endmodule

// ----- rtl/core/lnrr_checker.sv -----
// Port-level checker of the luminance nearest ramp remap block and its bind.
// Watches the handshakes of the two channels over time.
// Depends on luminance_nearest_ramp_remap.
module lnrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_mapped_index
);

   // After reset no result is shown and an item can be taken.
   assert property (@(posedge clock) reset |=> (!rsp_valid && req_ready))
      else $error("state after reset is wrong");

   // The block works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is at work");

   // A new result only appears at the end of an item's work.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> !$past(req_ready))
      else $error("result shown while the block was idle");

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mapped_index)))
      else $error("stalled result changed");

endmodule

bind luminance_nearest_ramp_remap lnrr_checker u_lnrr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_mapped_index (rsp_ch.mapped_index)
);
